FILE: design/trrs_pkg.sv
// Package for the task table round-robin scheduler.
// Holds sizes, slot and status codes and the controller/datapath command types.
// Depends on nothing.
package trrs_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int CPU_COUNT  = 4;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CPU_IW     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_UNUSED     = 2'd0,
    ST_RUNNABLE   = 2'd1,
    ST_RUNNING    = 2'd2,
    ST_TERMINATED = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_NO_FREE       = 2'd1,
    STATUS_NONE_RUNNABLE = 2'd2,
    STATUS_NO_CURRENT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_SCHED  = 2'd1,
    REQ_YIELD  = 2'd2,
    REQ_KILL   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ASEL_HOLD,
    ASEL_ZERO,
    ASEL_TARGET,
    ASEL_CURRENT,
    ASEL_POINTER,
    ASEL_NEXT
  } addr_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MARK,
    ACT_RELEASE,
    ACT_CREATE,
    ACT_DISPATCH,
    ACT_FAIL
  } action_t;

  typedef struct packed {
    logic      latch;
    addr_sel_t addr_sel;
    action_t   action;
    status_t   fail_status;
    logic      load;
  } ctrl_cmd_t;

  typedef struct packed {
    req_kind_t   req_kind;
    logic        cpu_ok;
    logic        target_ok;
    logic        cur_valid;
    slot_state_t slot_st;
    logic        out_free;
  } dp_status_t;

endpackage

FILE: design/trrs_if.sv
// Valid/ready channel interfaces for requests and results.
// Stand-alone; widths follow the request and result fields.
interface trrs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] cpu_index;
  logic [3:0] target_slot;

  modport source (output valid, req_type, cpu_index, target_slot, input ready);
  modport sink (input valid, req_type, cpu_index, target_slot, output ready);
endinterface

interface trrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_index;
  logic [31:0] task_id;

  modport source (output valid, status, slot_index, task_id, input ready);
  modport sink (input valid, status, slot_index, task_id, output ready);
endinterface

FILE: design/task_table_round_robin_scheduler.sv
// Top level of the task table round-robin scheduler.
// Depends on trrs_pkg, trrs_if, trrs_ctrl and trrs_dp.
//
// Requests arrive on the req channel (req_type, cpu_index, target_slot) and
// each produces exactly one result on the rsp channel (status, slot_index,
// task_id). A transfer takes place when valid and ready are both high.
// One request is worked on at a time; req.ready is high only while the
// controller is idle. A create or a schedule scans the table one slot per
// cycle, over at most SLOT_COUNT slots, as there is a single read address
// into the slot table; a yield or a kill needs no scan. The controller
// returns to idle after each load.
// The result sits in an output register, so a new request is taken while
// the previous result still waits; if the receiver stalls, the following
// result is held in the datapath until the output register empties.
// Synchronous reset marks every slot unused, clears all ids, per-CPU
// records and the id counter, and empties the output register.
module task_table_round_robin_scheduler
  import trrs_pkg::*;
(
  input logic     clk,
  input logic     rst,
  trrs_req_if.sink   req,
  trrs_rsp_if.source rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  trrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trrs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (req.req_type),
    .in_cpu_index   (req.cpu_index),
    .in_target_slot (req.target_slot),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_slot_index (rsp.slot_index),
    .out_task_id    (rsp.task_id)
  );

endmodule

FILE: design/trrs_dp.sv
// Datapath of the scheduler: slot table, per-CPU records, pending and output result.
// Depends on trrs_pkg; driven by trrs_ctrl through ctrl_cmd_t.
module trrs_dp
  import trrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  stat,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_cpu_index,
  input  logic [3:0]  in_target_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_task_id
);

  slot_state_t             slot_state [SLOT_COUNT];
  logic [31:0]             slot_id [SLOT_COUNT];
  logic [CPU_COUNT-1:0]    cpu_current_valid;
  logic [SLOT_W-1:0]       cpu_current_slot [CPU_COUNT];
  logic [SLOT_W-1:0]       cpu_scan_pointer [CPU_COUNT];
  logic [31:0]             last_id;

  req_kind_t               lat_req;
  logic [1:0]              lat_cpu;
  logic [3:0]              lat_target;
  logic [SLOT_W-1:0]       addr;
  logic [SLOT_W-1:0]       addr_next;
  logic [SLOT_W-1:0]       addr_inc;
  logic [CPU_IW-1:0]       cpu_idx;
  logic [1:0]              pend_status;
  logic [SLOT_W-1:0]       pend_slot;
  logic [31:0]             pend_id;
  logic [31:0]             id_next;
  slot_state_t             cur_st;

  assign cpu_idx  = CPU_IW'(lat_cpu);
  assign addr_inc = (addr == SLOT_W'(SLOT_COUNT - 1)) ? '0 : addr + 1'b1;
  assign cur_st   = slot_state[addr];
  assign id_next  = last_id + 32'd1;

  always_comb begin
    case (cmd.addr_sel)
      ASEL_ZERO:    addr_next = '0;
      ASEL_TARGET:  addr_next = SLOT_W'(lat_target);
      ASEL_CURRENT: addr_next = cpu_current_slot[cpu_idx];
      ASEL_POINTER: addr_next = cpu_scan_pointer[cpu_idx];
      ASEL_NEXT:    addr_next = addr_inc;
      default:      addr_next = addr;
    endcase
  end

  always_comb begin
    stat.req_kind  = lat_req;
    stat.cpu_ok    = (32'(lat_cpu) < CPU_COUNT);
    stat.target_ok = (32'(lat_target) < SLOT_COUNT);
    stat.cur_valid = stat.cpu_ok && cpu_current_valid[cpu_idx];
    stat.slot_st   = cur_st;
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_state[i] <= ST_UNUSED;
        slot_id[i]    <= '0;
      end
      for (int c = 0; c < CPU_COUNT; c++) begin
        cpu_current_slot[c] <= '0;
        cpu_scan_pointer[c] <= '0;
      end
      cpu_current_valid <= '0;
      last_id           <= '0;
      out_valid         <= 1'b0;
      addr              <= '0;
    end else begin
      if (cmd.latch) begin
        lat_req    <= req_kind_t'(in_req_type);
        lat_cpu    <= in_cpu_index;
        lat_target <= in_target_slot;
      end
      addr <= addr_next;
      case (cmd.action)
        ACT_MARK: begin
          slot_state[addr] <= ST_TERMINATED;
        end
        ACT_RELEASE: begin
          slot_state[addr]           <= (cur_st == ST_TERMINATED) ? ST_UNUSED : ST_RUNNABLE;
          cpu_current_valid[cpu_idx] <= 1'b0;
          pend_status                <= STATUS_OK;
          pend_slot                  <= addr;
          pend_id                    <= slot_id[addr];
        end
        ACT_CREATE: begin
          last_id          <= id_next;
          slot_id[addr]    <= id_next;
          slot_state[addr] <= ST_RUNNABLE;
          pend_status      <= STATUS_OK;
          pend_slot        <= addr;
          pend_id          <= id_next;
        end
        ACT_DISPATCH: begin
          slot_state[addr]           <= ST_RUNNING;
          cpu_current_valid[cpu_idx] <= 1'b1;
          cpu_current_slot[cpu_idx]  <= addr;
          cpu_scan_pointer[cpu_idx]  <= addr_inc;
          pend_status                <= STATUS_OK;
          pend_slot                  <= addr;
          pend_id                    <= slot_id[addr];
        end
        ACT_FAIL: begin
          pend_status <= cmd.fail_status;
          pend_slot   <= '0;
          pend_id     <= '0;
        end
        default: begin
        end
      endcase
      if (cmd.load) begin
        out_valid      <= 1'b1;
        out_status     <= pend_status;
        out_slot_index <= 4'(pend_slot);
        out_task_id    <= pend_id;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/trrs_ctrl.sv
// Controller of the scheduler: sequences decode, release, scans and result transfer.
// Depends on trrs_pkg; commands trrs_dp and reads its status.
module trrs_ctrl
  import trrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_KILL,
    S_REL_CHECK,
    S_RELEASE,
    S_SC_LOAD,
    S_SC_SCAN,
    S_CR_SCAN,
    S_RESULT
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] cnt_next;
  logic              is_sched;
  logic              cnt_last;

  assign is_sched = (stat.req_kind == REQ_SCHED);
  assign cnt_last = (cnt == SLOT_W'(SLOT_COUNT - 1));
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.addr_sel    = ASEL_HOLD;
    cmd.action      = ACT_NONE;
    cmd.fail_status = STATUS_OK;
    state_next      = state;
    cnt_next        = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req_kind)
          REQ_CREATE: begin
            cmd.addr_sel = ASEL_ZERO;
            cnt_next     = '0;
            state_next   = S_CR_SCAN;
          end
          REQ_SCHED: begin
            if (stat.cpu_ok) begin
              state_next = S_REL_CHECK;
            end else begin
              cmd.action      = ACT_FAIL;
              cmd.fail_status = STATUS_NONE_RUNNABLE;
              state_next      = S_RESULT;
            end
          end
          REQ_YIELD: state_next = S_REL_CHECK;
          default: begin
            cmd.addr_sel = ASEL_TARGET;
            state_next   = S_KILL;
          end
        endcase
      end
      S_KILL: begin
        if (stat.target_ok && stat.slot_st != ST_UNUSED) begin
          cmd.action = ACT_MARK;
        end
        state_next = S_REL_CHECK;
      end
      S_REL_CHECK: begin
        if (stat.cur_valid) begin
          cmd.addr_sel = ASEL_CURRENT;
          state_next   = S_RELEASE;
        end else if (is_sched) begin
          state_next = S_SC_LOAD;
        end else begin
          cmd.action      = ACT_FAIL;
          cmd.fail_status = STATUS_NO_CURRENT;
          state_next      = S_RESULT;
        end
      end
      S_RELEASE: begin
        cmd.action = ACT_RELEASE;
        state_next = is_sched ? S_SC_LOAD : S_RESULT;
      end
      S_SC_LOAD: begin
        cmd.addr_sel = ASEL_POINTER;
        cnt_next     = '0;
        state_next   = S_SC_SCAN;
      end
      S_SC_SCAN: begin
        if (stat.slot_st == ST_RUNNABLE) begin
          cmd.action = ACT_DISPATCH;
          state_next = S_RESULT;
        end else if (cnt_last) begin
          cmd.action      = ACT_FAIL;
          cmd.fail_status = STATUS_NONE_RUNNABLE;
          state_next      = S_RESULT;
        end else begin
          cmd.addr_sel = ASEL_NEXT;
          cnt_next     = cnt + 1'b1;
        end
      end
      S_CR_SCAN: begin
        if (stat.slot_st == ST_UNUSED) begin
          cmd.action = ACT_CREATE;
          state_next = S_RESULT;
        end else if (cnt_last) begin
          cmd.action      = ACT_FAIL;
          cmd.fail_status = STATUS_NO_FREE;
          state_next      = S_RESULT;
        end else begin
          cmd.addr_sel = ASEL_NEXT;
          cnt_next     = cnt + 1'b1;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
